/* design/swik_pkg.sv */
// ----------------------------------------------------------------------------
// swik_pkg
// Shared types and constants for the spherical wrist inverse kinematics block.
// ----------------------------------------------------------------------------
package swik_pkg;

    // cordic constants, radians in Q30
    localparam longint PI_Q30      = 64'd3373259426;
    localparam longint TWO_PI_Q30  = 64'd6746518852;
    localparam longint HALF_PI_Q30 = 64'd1686629713;
    localparam longint GAIN_Q30    = 64'd652032874;
    localparam int     MAX_STEPS   = 24;

    // configuration register indexes
    localparam logic CFG_JOINT_OFFSET       = 1'b0;
    localparam logic CFG_SINGULAR_THRESHOLD = 1'b1;

    // reset values: 0.06305 rad in Q3.13 and 0.99 in Q1.14
    localparam logic [12:0] JOINT_OFFSET_RST = 13'd517;
    localparam logic [14:0] THRESHOLD_RST    = 15'd16220;

    // prepared item queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // prepared item: hip angle, joint two minus joint three, target matrix
    typedef struct packed {
        logic signed [15:0] q1;
        logic signed [16:0] qd;
        logic [8:0][15:0]   m;
    } item_t;

    // arctangent of 2^-i in Q30
    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] v;
        case (i)
            0:       v = 32'd843314857;
            1:       v = 32'd497837829;
            2:       v = 32'd263043837;
            3:       v = 32'd133525159;
            4:       v = 32'd67021687;
            5:       v = 32'd33543516;
            6:       v = 32'd16775851;
            7:       v = 32'd8388437;
            8:       v = 32'd4194283;
            9:       v = 32'd2097149;
            10:      v = 32'd1048576;
            11:      v = 32'd524288;
            12:      v = 32'd262144;
            13:      v = 32'd131072;
            14:      v = 32'd65536;
            15:      v = 32'd32768;
            16:      v = 32'd16384;
            17:      v = 32'd8192;
            18:      v = 32'd4096;
            19:      v = 32'd2048;
            20:      v = 32'd1024;
            21:      v = 32'd512;
            22:      v = 32'd256;
            23:      v = 32'd128;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

/* design/spherical_wrist_inverse_kinematics.sv */
// ----------------------------------------------------------------------------
// spherical_wrist_inverse_kinematics
// Wrist joint angles from the first three joints and a target rotation.
// ----------------------------------------------------------------------------
// Usage:
//   s_* takes one beat per solve: hip, shoulder, elbow angles (Q3.13) and the
//   nine target matrix entries (Q1.14), row-major. m_* returns one beat per
//   solve: wrist yaw, pitch, roll (Q3.13) and the solved flag; a singular
//   wrist returns all zeros.
//   cfg_* writes joint_offset (index 0) or singular_threshold (index 1); it
//   is always ready. The user must write it only while no solve is in flight;
//   the block itself does not enforce this. Throughput: one beat per cycle
//   while the output is not stalled. An input beat passes the input register,
//   the queue, the two chained cordic pipelines and the square root pipeline
//   on its way to the output beat.
// Reset clears all valid state and loads the register reset values.
// When an output beat waits and m_tready is low the datapath holds; the input
//   register and a four entry queue keep taking beats until they fill, then s_tready drops.
// ----------------------------------------------------------------------------
module spherical_wrist_inverse_kinematics
    import swik_pkg::*;
#(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 13
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // hip_angle, shoulder_angle, elbow_angle, rot_00 .. rot_22, 16 bits each
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // wrist_yaw[15:0], wrist_pitch[30:16], wrist_roll[46:31], solved[47]
    output logic [47:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data
);

    logic        push;
    logic        push_ready;
    item_t       push_item;
    logic        pop_valid;
    logic        pop_ready;
    item_t       pop_item;
    logic [14:0] threshold;

    // accept and prepare
    swik_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .push_ready (push_ready),
        .push_item  (push_item),
        .threshold  (threshold)
    );

    // decoupling queue
    swik_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // solve
    swik_back #(
        .CORDIC_STEPS    (CORDIC_STEPS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pop_valid),
        .in_ready  (pop_ready),
        .in_item   (pop_item),
        .threshold (threshold),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

/* design/swik_front.sv */
// ----------------------------------------------------------------------------
// swik_front
// Input register, configuration registers and joint angle preparation.
// ----------------------------------------------------------------------------
module swik_front
    import swik_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data,
    output logic         push,
    input  logic         push_ready,
    output item_t        push_item,
    output logic [14:0]  threshold
);

    logic         hold_vld_reg;
    logic [191:0] hold_data_reg;
    logic [12:0]  offset_reg;
    logic [14:0]  thresh_reg;
    logic signed [17:0] q2;
    logic signed [17:0] q3;
    logic signed [18:0] qdiff;

    // configuration writes
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= JOINT_OFFSET_RST;
            thresh_reg <= THRESHOLD_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_JOINT_OFFSET:       offset_reg <= cfg_data[12:0];
                CFG_SINGULAR_THRESHOLD: thresh_reg <= cfg_data[14:0];
                default:                ;
            endcase
        end
    end
    assign threshold = thresh_reg;

    // input holding register
    assign push     = hold_vld_reg && push_ready;
    assign s_tready = !hold_vld_reg || push_ready;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_vld_reg <= 1'b0;
        else if (s_tready)
            hold_vld_reg <= s_tvalid;
    end
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            hold_data_reg <= s_tdata;
    end

    // offset joints two and three, only their difference reaches the trig
    assign q2 = $signed({hold_data_reg[31], hold_data_reg[31], hold_data_reg[31:16]})
              - $signed({5'b0, offset_reg});
    assign q3 = $signed({hold_data_reg[47], hold_data_reg[47], hold_data_reg[47:32]})
              - $signed({5'b0, offset_reg});
    assign qdiff = {q2[17], q2} - {q3[17], q3};

    always_comb
    begin
        push_item.q1 = $signed(hold_data_reg[15:0]);
        push_item.qd = qdiff[16:0];
        for (int i = 0; i < 9; i++)
            push_item.m[i] = hold_data_reg[48 + 16*i +: 16];
    end

endmodule

/* design/swik_queue.sv */
// ----------------------------------------------------------------------------
// swik_queue
// Short queue of prepared items between the front and the datapath.
// ----------------------------------------------------------------------------
module swik_queue
    import swik_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    item_t                 buf_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg;
    logic                  pop;

    assign push_ready = (count_reg != QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = buf_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_ptr_reg] <= push_item;
    end

endmodule

/* design/swik_back.sv */
// ----------------------------------------------------------------------------
// swik_back
// Pipelined datapath: angle reduction, sin/cos cordic, matrix product,
// singularity test, square root and atan2 cordic.
// ----------------------------------------------------------------------------
module swik_back
    import swik_pkg::*;
#(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 13
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  item_t       in_item,
    input  logic [14:0] threshold,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [47:0] out_data
);

    localparam int STEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
    localparam int SH    = 30 - ANGLE_FRAC_BITS;
    localparam int RDW   = 40;
    localparam int XW    = 34;
    localparam int ZW    = 36;
    localparam int SW    = 18;
    localparam int RW    = 22;
    localparam int TW    = 34;
    localparam int RED_N = 4;
    localparam int SQ_N  = 15;
    // stage numbers
    localparam int ST_FOLD = 1 + RED_N;
    localparam int ST_MUL  = ST_FOLD + STEPS + 2;
    localparam int LAT     = ST_MUL + 4 + SQ_N + 1 + STEPS + 1;

    localparam logic signed [RDW-1:0] TWO_PI_R = RDW'(TWO_PI_Q30);
    localparam logic signed [RDW-1:0] PI_R     = RDW'(PI_Q30);
    localparam logic signed [RDW-1:0] HALF_R   = RDW'(HALF_PI_Q30);
    localparam logic signed [XW-1:0]  GAIN_X   = XW'(GAIN_Q30);
    localparam logic signed [ZW-1:0]  HALF_Z   = ZW'(HALF_PI_Q30);
    localparam logic signed [ZW-1:0]  RND_Z    = ZW'(64'd1 << (SH - 1));
    localparam logic signed [ZW-1:0]  PI_F     = ZW'((PI_Q30 + (64'd1 << (SH - 1))) >> SH);

    logic [LAT-1:0] vld_reg;
    logic           adv;

    // the whole pipe moves when the output register is empty or being taken
    assign adv       = !vld_reg[LAT-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    // matrix rides along until the product stage
    logic [8:0][15:0] m_d_reg [ST_MUL+1];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_d_reg[0] <= in_item.m;
            for (int i = 1; i <= ST_MUL; i++)
                m_d_reg[i] <= m_d_reg[i-1];
        end
    end

    // angle reduction, three angles: q1, q2-q3, q3-q2
    logic signed [RDW-1:0] rm_reg  [3][RED_N+1];
    logic                  rs_reg  [3][RED_N+1];
    logic signed [XW-1:0]  cx_reg  [3][STEPS+1];
    logic signed [XW-1:0]  cy_reg  [3][STEPS+1];
    logic signed [ZW-1:0]  cz_reg  [3][STEPS+1];
    logic                  neg_reg [3][STEPS+1];
    logic signed [SW-1:0]  c1_reg, s1_reg, c23_reg, s32_reg;

    genvar k, j, i;
    generate
        for (k = 0; k < 3; k++)
        begin : g_sc
            logic signed [17:0]    ang;
            logic signed [RDW-1:0] sc;
            logic signed [RDW-1:0] zz;
            logic signed [RDW-1:0] zf;
            logic                  nf;

            // scale to Q30 and take the magnitude
            always_comb
            begin
                case (k)
                    0:       ang = {in_item.q1[15], in_item.q1[15], in_item.q1};
                    1:       ang = {in_item.qd[16], in_item.qd};
                    default: ang = -{in_item.qd[16], in_item.qd};
                endcase
                sc = {{(RDW-18){ang[17]}}, ang} <<< SH;
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rm_reg[k][0] <= sc[RDW-1] ? -sc : sc;
                    rs_reg[k][0] <= sc[RDW-1];
                end
            end

            // magnitude modulo two pi, one multiple per stage
            for (j = 0; j < RED_N; j++)
            begin : g_red
                logic signed [RDW-1:0] lim;
                assign lim = TWO_PI_R <<< (RED_N - 1 - j);
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        rm_reg[k][j+1] <= (rm_reg[k][j] >= lim) ? rm_reg[k][j] - lim
                                                                : rm_reg[k][j];
                        rs_reg[k][j+1] <= rs_reg[k][j];
                    end
                end
            end

            // restore sign, wrap to [-pi, pi], fold into the right half plane
            always_comb
            begin
                zz = rs_reg[k][RED_N] ? -rm_reg[k][RED_N] : rm_reg[k][RED_N];
                if (zz > PI_R)
                    zz = zz - TWO_PI_R;
                else if (zz < -PI_R)
                    zz = zz + TWO_PI_R;
                nf = 1'b0;
                zf = zz;
                if (zz > HALF_R)
                begin
                    zf = zz - PI_R;
                    nf = 1'b1;
                end
                else if (zz < -HALF_R)
                begin
                    zf = zz + PI_R;
                    nf = 1'b1;
                end
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    cx_reg[k][0]  <= GAIN_X;
                    cy_reg[k][0]  <= '0;
                    cz_reg[k][0]  <= zf[ZW-1:0];
                    neg_reg[k][0] <= nf;
                end
            end

            // rotation mode cordic
            for (i = 0; i < STEPS; i++)
            begin : g_rot
                logic signed [ZW-1:0] at;
                assign at = {{(ZW-32){1'b0}}, atan_q30(i)};
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        if (!cz_reg[k][i][ZW-1])
                        begin
                            cx_reg[k][i+1] <= cx_reg[k][i] - (cy_reg[k][i] >>> i);
                            cy_reg[k][i+1] <= cy_reg[k][i] + (cx_reg[k][i] >>> i);
                            cz_reg[k][i+1] <= cz_reg[k][i] - at;
                        end
                        else
                        begin
                            cx_reg[k][i+1] <= cx_reg[k][i] + (cy_reg[k][i] >>> i);
                            cy_reg[k][i+1] <= cy_reg[k][i] - (cx_reg[k][i] >>> i);
                            cz_reg[k][i+1] <= cz_reg[k][i] + at;
                        end
                        neg_reg[k][i+1] <= neg_reg[k][i];
                    end
                end
            end
        end
    endgenerate

    // sign fix and rounding of sin and cos to Q14
    logic signed [XW-1:0] xr0, yr0, xr1, yr2;
    always_comb
    begin
        xr0 = (neg_reg[0][STEPS] ? -cx_reg[0][STEPS] : cx_reg[0][STEPS]) + XW'(32768);
        yr0 = (neg_reg[0][STEPS] ? -cy_reg[0][STEPS] : cy_reg[0][STEPS]) + XW'(32768);
        xr1 = (neg_reg[1][STEPS] ? -cx_reg[1][STEPS] : cx_reg[1][STEPS]) + XW'(32768);
        yr2 = (neg_reg[2][STEPS] ? -cy_reg[2][STEPS] : cy_reg[2][STEPS]) + XW'(32768);
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_reg  <= xr0[XW-1:16];
            s1_reg  <= yr0[XW-1:16];
            c23_reg <= xr1[XW-1:16];
            s32_reg <= yr2[XW-1:16];
        end
    end

    // arm frame entries
    logic signed [2*SW-1:0] p0, p1, p2, p3;
    logic signed [SW-1:0]   a00_reg, a01_reg, a02_reg, a10_reg, a11_reg, a12_reg;
    logic signed [SW-1:0]   a20_reg, a22_reg;
    always_comb
    begin
        p0 = c1_reg * s32_reg + (2*SW)'(8192);
        p1 = c1_reg * c23_reg + (2*SW)'(8192);
        p2 = s1_reg * s32_reg + (2*SW)'(8192);
        p3 = s1_reg * c23_reg + (2*SW)'(8192);
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a00_reg <= p0[SW+13:14];
            a02_reg <= -p1[SW+13:14];
            a10_reg <= p2[SW+13:14];
            a12_reg <= -p3[SW+13:14];
            a01_reg <= -s1_reg;
            a11_reg <= c1_reg;
            a20_reg <= c23_reg;
            a22_reg <= s32_reg;
        end
    end

    // products for the needed entries of transpose(A) * M
    logic [8:0][15:0]       mm;
    logic signed [SW+15:0]  pr_reg [14];
    assign mm = m_d_reg[ST_MUL];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pr_reg[0]  <= a00_reg * $signed(mm[2]);
            pr_reg[1]  <= a10_reg * $signed(mm[5]);
            pr_reg[2]  <= a20_reg * $signed(mm[8]);
            pr_reg[3]  <= a01_reg * $signed(mm[2]);
            pr_reg[4]  <= a11_reg * $signed(mm[5]);
            pr_reg[5]  <= a02_reg * $signed(mm[2]);
            pr_reg[6]  <= a12_reg * $signed(mm[5]);
            pr_reg[7]  <= a22_reg * $signed(mm[8]);
            pr_reg[8]  <= a02_reg * $signed(mm[0]);
            pr_reg[9]  <= a12_reg * $signed(mm[3]);
            pr_reg[10] <= a22_reg * $signed(mm[6]);
            pr_reg[11] <= a02_reg * $signed(mm[1]);
            pr_reg[12] <= a12_reg * $signed(mm[4]);
            pr_reg[13] <= a22_reg * $signed(mm[7]);
        end
    end

    // sums rounded to Q14
    logic signed [35:0]   sm [5];
    logic signed [RW-1:0] r02_reg, r12_reg, r22_reg, r20_reg, r21_reg;
    always_comb
    begin
        sm[0] = 36'(pr_reg[0]) + 36'(pr_reg[1]) + 36'(pr_reg[2]) + 36'sd8192;
        sm[1] = 36'(pr_reg[3]) + 36'(pr_reg[4]) + 36'sd8192;
        sm[2] = 36'(pr_reg[5]) + 36'(pr_reg[6]) + 36'(pr_reg[7]) + 36'sd8192;
        sm[3] = 36'(pr_reg[8]) + 36'(pr_reg[9]) + 36'(pr_reg[10]) + 36'sd8192;
        sm[4] = 36'(pr_reg[11]) + 36'(pr_reg[12]) + 36'(pr_reg[13]) + 36'sd8192;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r02_reg <= sm[0][35:14];
            r12_reg <= sm[1][35:14];
            r22_reg <= sm[2][35:14];
            r20_reg <= sm[3][35:14];
            r21_reg <= sm[4][35:14];
        end
    end

    // singularity test and square root radicand
    logic signed [RW-1:0] nv, absv;
    logic signed [15:0]   vc;
    logic signed [31:0]   rad;
    always_comb
    begin
        nv   = -r22_reg;
        absv = r22_reg[RW-1] ? nv : r22_reg;
        if (nv > RW'(16384))
            vc = 16'sd16384;
        else if (nv < -RW'(16384))
            vc = -16'sd16384;
        else
            vc = nv[15:0];
        rad = 32'sd268435456 - vc * vc;
    end

    logic [28:0]          sq_rem_reg [SQ_N+1];
    logic [28:0]          sq_res_reg [SQ_N+1];
    logic signed [15:0]   v_d_reg    [SQ_N+1];
    logic                 sing_d_reg [SQ_N+1];
    logic signed [RW-1:0] yy_d_reg   [SQ_N+1];
    logic signed [RW-1:0] yx_d_reg   [SQ_N+1];
    logic signed [RW-1:0] ry_d_reg   [SQ_N+1];
    logic signed [RW-1:0] rx_d_reg   [SQ_N+1];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_rem_reg[0] <= rad[28:0];
            sq_res_reg[0] <= '0;
            v_d_reg[0]    <= vc;
            sing_d_reg[0] <= (absv >= $signed({7'b0, threshold}));
            yy_d_reg[0]   <= r12_reg;
            yx_d_reg[0]   <= r02_reg;
            ry_d_reg[0]   <= r21_reg;
            rx_d_reg[0]   <= -r20_reg;
        end
    end

    // floor square root, one result bit per stage
    generate
        for (i = 0; i < SQ_N; i++)
        begin : g_sqrt
            logic [28:0] bitv;
            logic [28:0] t;
            assign bitv = 29'd1 << (2 * (SQ_N - 1 - i));
            assign t    = sq_res_reg[i] + bitv;
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (sq_rem_reg[i] >= t)
                    begin
                        sq_rem_reg[i+1] <= sq_rem_reg[i] - t;
                        sq_res_reg[i+1] <= (sq_res_reg[i] >> 1) + bitv;
                    end
                    else
                    begin
                        sq_rem_reg[i+1] <= sq_rem_reg[i];
                        sq_res_reg[i+1] <= sq_res_reg[i] >> 1;
                    end
                    v_d_reg[i+1]    <= v_d_reg[i];
                    sing_d_reg[i+1] <= sing_d_reg[i];
                    yy_d_reg[i+1]   <= yy_d_reg[i];
                    yx_d_reg[i+1]   <= yx_d_reg[i];
                    ry_d_reg[i+1]   <= ry_d_reg[i];
                    rx_d_reg[i+1]   <= rx_d_reg[i];
                end
            end
        end
    endgenerate

    // three vectoring cordics: yaw, pitch, roll
    logic signed [TW-1:0] vx_reg   [3][STEPS+1];
    logic signed [TW-1:0] vy_reg   [3][STEPS+1];
    logic signed [ZW-1:0] vz_reg   [3][STEPS+1];
    logic                 zero_reg [3][STEPS+1];
    logic                 sing_a_reg [STEPS+1];
    logic signed [ZW-1:0] ang_out  [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sing_a_reg[0] <= sing_d_reg[SQ_N];
            for (int n = 1; n <= STEPS; n++)
                sing_a_reg[n] <= sing_a_reg[n-1];
        end
    end

    generate
        for (k = 0; k < 3; k++)
        begin : g_at
            logic signed [RW-1:0] oy, ox;
            logic signed [TW-1:0] sy, sx, qy, qx;
            logic signed [ZW-1:0] qz;
            logic signed [ZW-1:0] rr;

            always_comb
            begin
                case (k)
                    0:
                    begin
                        oy = yy_d_reg[SQ_N];
                        ox = yx_d_reg[SQ_N];
                    end
                    1:
                    begin
                        oy = RW'(sq_res_reg[SQ_N][15:0]);
                        ox = RW'(v_d_reg[SQ_N]);
                    end
                    default:
                    begin
                        oy = ry_d_reg[SQ_N];
                        ox = rx_d_reg[SQ_N];
                    end
                endcase
                sy = TW'(oy) <<< 12;
                sx = TW'(ox) <<< 12;
                qy = sy;
                qx = sx;
                qz = '0;
                if (sx[TW-1])
                begin
                    if (!sy[TW-1])
                    begin
                        qx = sy;
                        qy = -sx;
                        qz = HALF_Z;
                    end
                    else
                    begin
                        qx = -sy;
                        qy = sx;
                        qz = -HALF_Z;
                    end
                end
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    vx_reg[k][0]   <= qx;
                    vy_reg[k][0]   <= qy;
                    vz_reg[k][0]   <= qz;
                    zero_reg[k][0] <= (ox == '0) && (oy == '0);
                end
            end

            for (i = 0; i < STEPS; i++)
            begin : g_vec
                logic signed [ZW-1:0] at;
                assign at = {{(ZW-32){1'b0}}, atan_q30(i)};
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        if (!vy_reg[k][i][TW-1])
                        begin
                            vx_reg[k][i+1] <= vx_reg[k][i] + (vy_reg[k][i] >>> i);
                            vy_reg[k][i+1] <= vy_reg[k][i] - (vx_reg[k][i] >>> i);
                            vz_reg[k][i+1] <= vz_reg[k][i] + at;
                        end
                        else
                        begin
                            vx_reg[k][i+1] <= vx_reg[k][i] - (vy_reg[k][i] >>> i);
                            vy_reg[k][i+1] <= vy_reg[k][i] + (vx_reg[k][i] >>> i);
                            vz_reg[k][i+1] <= vz_reg[k][i] - at;
                        end
                        zero_reg[k][i+1] <= zero_reg[k][i];
                    end
                end
            end

            // round to output angle scale and clamp to [-pi, pi]
            always_comb
            begin
                rr = (vz_reg[k][STEPS] + RND_Z) >>> SH;
                if (rr > PI_F)
                    rr = PI_F;
                if (rr < -PI_F)
                    rr = -PI_F;
                if (zero_reg[k][STEPS])
                    rr = '0;
                ang_out[k] = rr;
            end
        end
    endgenerate

    // output register
    logic [47:0] out_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (sing_a_reg[STEPS])
                out_reg <= '0;
            else
                out_reg <= {1'b1, ang_out[2][15:0], ang_out[1][14:0], ang_out[0][15:0]};
        end
    end
    assign out_data = out_reg;

endmodule

/* sim/tb_spherical_wrist_inverse_kinematics.sv */
// ----------------------------------------------------------------------------
// tb_spherical_wrist_inverse_kinematics
// Self-checking bench for the wrist solver: drives random and corner-case
// solve beats under random stalls, predicts every result in fixed point and
// compares it field by field against the output stream.
// ----------------------------------------------------------------------------
module tb_spherical_wrist_inverse_kinematics
    import swik_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  N_STEPS   = 16;
    localparam int  FRAC_BITS = 13;
    localparam int  TAIL      = 100;
    localparam longint LIMIT  = 600000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [47:0]  m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic         cfg_index;
    logic [15:0]  cfg_data;

    // arctangent of 2^-i in Q30
    longint atan_tab [24] = '{
        843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
        524288, 262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128
    };

    // predictor copy of the registers
    logic [12:0]  offset_reg;
    logic [14:0]  thresh_reg;

    logic [47:0]  wrist_q [$];
    int           err_cnt;
    int           src_idle_pct;
    int           snk_idle_pct;
    int           hold_cycles;
    longint       cycle_cnt;

    spherical_wrist_inverse_kinematics dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // cosine and sine in Q14 of an angle in Q3.13
    function automatic void sin_cos(input longint ang, output longint c, output longint s);
        longint z, x, y, t;
        bit     neg;
        z = (ang * (64'sd1 <<< (30 - FRAC_BITS))) % TWO_PI_Q30;
        x = GAIN_Q30;
        y = 0;
        neg = 1'b0;
        if (z > PI_Q30) z -= TWO_PI_Q30;
        if (z < -PI_Q30) z += TWO_PI_Q30;
        if (z > HALF_PI_Q30)
        begin
            z -= PI_Q30;
            neg = 1'b1;
        end
        else if (z < -HALF_PI_Q30)
        begin
            z += PI_Q30;
            neg = 1'b1;
        end
        for (int i = 0; i < N_STEPS; i++)
        begin
            if (z >= 0)
            begin
                t = x - (y >>> i); y = y + (x >>> i); x = t; z -= atan_tab[i];
            end
            else
            begin
                t = x + (y >>> i); y = y - (x >>> i); x = t; z += atan_tab[i];
            end
        end
        if (neg)
        begin
            x = -x;
            y = -y;
        end
        c = (x + 32768) >>> 16;
        s = (y + 32768) >>> 16;
    endfunction

    // atan2 of Q14 operands into Q3.13, clamped to pi
    function automatic longint arc_tan2(input longint yi, input longint xi);
        longint x, y, z, t, r, pi_f;
        z = 0;
        if (xi == 0 && yi == 0) return 0;
        x = xi * 4096;
        y = yi * 4096;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = y; y = -x; x = t; z = HALF_PI_Q30;
            end
            else
            begin
                t = -y; y = x; x = t; z = -HALF_PI_Q30;
            end
        end
        for (int i = 0; i < N_STEPS; i++)
        begin
            if (y >= 0)
            begin
                t = x + (y >>> i); y = y - (x >>> i); x = t; z += atan_tab[i];
            end
            else
            begin
                t = x - (y >>> i); y = y + (x >>> i); x = t; z -= atan_tab[i];
            end
        end
        r = (z + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        pi_f = (PI_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        if (r > pi_f) r = pi_f;
        if (r < -pi_f) r = -pi_f;
        return r;
    endfunction

    // integer floor square root
    function automatic longint floor_sqrt(input longint v);
        longint res, b;
        res = 0;
        b = 64'sd1 <<< 30;
        while (b > v) b = b >>> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >>> 1) + b;
            end
            else
                res = res >>> 1;
            b = b >>> 2;
        end
        return res;
    endfunction

    function automatic longint mul14(input longint a, input longint b);
        return (a * b + 8192) >>> 14;
    endfunction

    // expected wrist angles for one solve beat
    function automatic logic [47:0] solve_wrist(input logic [191:0] d);
        longint q1, q2, q3, c1, s1, c23, s32, unused_s, unused_c, v, sq, acc;
        longint m [3][3];
        longint a [3][3];
        longint r [3][3];
        logic [15:0] yaw, roll;
        logic [14:0] pitch;
        q1 = longint'($signed(d[15:0]));
        q2 = longint'($signed(d[31:16])) - longint'(offset_reg);
        q3 = longint'($signed(d[47:32])) - longint'(offset_reg);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = longint'($signed(d[48 + 16 * (i * 3 + j) +: 16]));
        sin_cos(q1, c1, s1);
        sin_cos(q2 - q3, c23, unused_s);
        sin_cos(q3 - q2, unused_c, s32);
        a[0][0] = mul14(c1, s32); a[0][1] = -s1; a[0][2] = -mul14(c1, c23);
        a[1][0] = mul14(s1, s32); a[1][1] = c1;  a[1][2] = -mul14(s1, c23);
        a[2][0] = c23;            a[2][1] = 0;   a[2][2] = s32;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += a[k][i] * m[k][j];
                r[i][j] = (acc + 8192) >>> 14;
            end
        v = (r[2][2] < 0) ? -r[2][2] : r[2][2];
        if (v >= longint'(thresh_reg)) return 48'd0;
        v = -r[2][2];
        if (v > 16384) v = 16384;
        if (v < -16384) v = -16384;
        sq = floor_sqrt(16384 * 16384 - v * v);
        yaw   = 16'(arc_tan2(r[1][2], r[0][2]));
        pitch = 15'(arc_tan2(sq, v));
        roll  = 16'(arc_tan2(r[2][1], -r[2][0]));
        return {1'b1, roll, pitch, yaw};
    endfunction

    // receiver ready, with a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready    <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        logic [47:0] exp_w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (wrist_q.size() == 0)
            begin
                $error("unexpected result beat %h", m_tdata);
                err_cnt++;
            end
            else
            begin
                exp_w = wrist_q.pop_front();
                if (m_tdata[15:0] !== exp_w[15:0])
                begin
                    $error("wrist_yaw exp %0d got %0d", $signed(exp_w[15:0]),
                           $signed(m_tdata[15:0]));
                    err_cnt++;
                end
                if (m_tdata[30:16] !== exp_w[30:16])
                begin
                    $error("wrist_pitch exp %0d got %0d", exp_w[30:16], m_tdata[30:16]);
                    err_cnt++;
                end
                if (m_tdata[46:31] !== exp_w[46:31])
                begin
                    $error("wrist_roll exp %0d got %0d", $signed(exp_w[46:31]),
                           $signed(m_tdata[46:31]));
                    err_cnt++;
                end
                if (m_tdata[47] !== exp_w[47])
                begin
                    $error("solved exp %0b got %0b", exp_w[47], m_tdata[47]);
                    err_cnt++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // send one solve beat, after a random gap
    task automatic send_beat(input logic [191:0] d);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = d;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        wrist_q.push_back(solve_wrist(d));
        @(negedge clk);
    endtask

    // wait for all results, then let the pipeline empty
    task automatic drain();
        s_tvalid = 1'b0;
        while (wrist_q.size() != 0) @(negedge clk);
        repeat (TAIL) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        drain();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == CFG_JOINT_OFFSET) offset_reg = val[12:0];
        else thresh_reg = val[14:0];
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [191:0] build_beat(input logic [15:0] j1, input logic [15:0] j2,
                                                input logic [15:0] j3, input logic [15:0] e);
        logic [191:0] d;
        d = {{9{e}}, j3, j2, j1};
        return d;
    endfunction

    function automatic logic [191:0] rand_beat();
        logic [191:0] d;
        int           mode;
        mode = $urandom_range(9);
        for (int i = 0; i < 12; i++)
        begin
            if (i < 3 || mode == 0)
                d[16 * i +: 16] = 16'($urandom);
            else if (mode == 1)
                // near identity-like entries pushing R22 toward a unit value
                d[16 * i +: 16] = (i == 11) ? 16'($urandom_range(32767))
                                            : 16'($signed($urandom_range(2000)) - 1000);
            else
                d[16 * i +: 16] = 16'($signed($urandom_range(32768)) - 16384);
        end
        return d;
    endfunction

    task automatic test_directed();
        logic [191:0] d;
        send_beat('0);
        send_beat({192{1'b1}});
        send_beat(build_beat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
        send_beat(build_beat(16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_beat(build_beat(16'h7fff, 16'h8000, 16'h7fff, 16'h4000));
        send_beat(build_beat(16'h8000, 16'h7fff, 16'h0000, 16'hc000));
        // identity target at zero joints
        d = '0;
        d[48 +: 16] = 16'd16384; d[112 +: 16] = 16'd16384; d[176 +: 16] = 16'd16384;
        send_beat(d);
        d[31:16] = 16'd12868;
        send_beat(d);
        // entries above one drive the acos argument out of range
        d[176 +: 16] = 16'h7fff;
        send_beat(d);
        d[176 +: 16] = 16'h8000;
        send_beat(d);
        for (int i = 0; i < 8; i++)
            send_beat(rand_beat());
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_JOINT_OFFSET, 16'd0);
        write_reg(CFG_SINGULAR_THRESHOLD, 16'd0);
        for (int i = 0; i < 20; i++) send_beat(rand_beat());
        write_reg(CFG_JOINT_OFFSET, 16'd4096);
        write_reg(CFG_SINGULAR_THRESHOLD, 16'd16384);
        for (int i = 0; i < 30; i++) send_beat(rand_beat());
        write_reg(CFG_SINGULAR_THRESHOLD, 16'h7fff);
        for (int i = 0; i < 20; i++) send_beat(rand_beat());
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        for (int i = 0; i < 60; i++) send_beat(rand_beat());
        drain();
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            if (i % 90 == 89)
            begin
                write_reg(CFG_JOINT_OFFSET, 16'($urandom_range(4096)));
                write_reg(CFG_SINGULAR_THRESHOLD, 16'($urandom_range(16384, 8000)));
            end
            send_beat(rand_beat());
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_JOINT_OFFSET;
        cfg_data     = '0;
        m_tready     = 1'b0;
        hold_cycles  = 0;
        err_cnt      = 0;
        cycle_cnt    = 0;
        offset_reg   = JOINT_OFFSET_RST;
        thresh_reg   = THRESHOLD_RST;
        src_idle_pct = 26;
        snk_idle_pct = 78;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_config_extremes();
        test_backpressure();
        write_reg(CFG_JOINT_OFFSET, 16'd517);
        write_reg(CFG_SINGULAR_THRESHOLD, 16'd16220);
        test_random(500);
        src_idle_pct = 78;
        snk_idle_pct = 26;
        test_random(500);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random(520);

        drain();
        if (err_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
